[src/assert_macros.svh]
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/apt_pkg.sv]
package apt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int COEF_W      = 32;
  localparam int CW          = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
  localparam int PROD_W      = COEF_W + CW;
  localparam int RND_W       = PROD_W - FRAC_BITS;
  localparam int SUM_W       = ((RND_W > COEF_W) ? RND_W : COEF_W) + 2;
  localparam int NUM_STAGES  = 4;
  localparam int REG_IDX_W   = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_A  = 3'd0,
    REG_COEF_B  = 3'd1,
    REG_COEF_C  = 3'd2,
    REG_COEF_D  = 3'd3,
    REG_TRANS_E = 3'd4,
    REG_TRANS_F = 3'd5
  } cfg_reg_e;

  localparam logic signed [COEF_W-1:0] UNITY = COEF_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = ~COORD_MAX;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(COORD_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(COORD_MIN);

  localparam logic signed [FIELD_W-1:0] OUT_MAX = FIELD_W'(COORD_MAX);
  localparam logic signed [FIELD_W-1:0] OUT_MIN = FIELD_W'(COORD_MIN);

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] e;
    logic signed [COEF_W-1:0] f;
  } coef_t;

  // stage load enables, one per pipeline register rank
  typedef struct packed {
    logic mul;
    logic rnd;
    logic add;
    logic sat;
  } pipe_en_t;

endpackage

[src/apt_if.sv]
interface apt_point_if import apt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] x_in;
  logic signed [FIELD_W-1:0] y_in;
  logic                      last_in;

  modport source (output valid, x_in, y_in, last_in, input ready);
  modport sink   (input valid, x_in, y_in, last_in, output ready);
endinterface

interface apt_result_if import apt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] x_out;
  logic signed [FIELD_W-1:0] y_out;
  logic                      last_out;
  logic                      overflow;

  modport source (output valid, x_out, y_out, last_out, overflow, input ready);
  modport sink   (input valid, x_out, y_out, last_out, overflow, output ready);
endinterface

interface apt_cfg_if import apt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REG_IDX_W-1:0]      index;
  logic [COEF_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/apt_cfg.sv]
module apt_cfg import apt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  apt_cfg_if.sink    cfg_i,
  output coef_t      coef_o
);

  coef_t coef_q;
  coef_t coef_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_COEF_A:  coef_d.a = cfg_i.data;
        REG_COEF_B:  coef_d.b = cfg_i.data;
        REG_COEF_C:  coef_d.c = cfg_i.data;
        REG_COEF_D:  coef_d.d = cfg_i.data;
        REG_TRANS_E: coef_d.e = cfg_i.data;
        REG_TRANS_F: coef_d.f = cfg_i.data;
        default:     coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.a <= UNITY;
      coef_q.b <= '0;
      coef_q.c <= '0;
      coef_q.d <= UNITY;
      coef_q.e <= '0;
      coef_q.f <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

[src/apt_lane.sv]
module apt_lane import apt_pkg::*; (
  input  logic                      clk_i,
  input  pipe_en_t                  en_i,
  input  logic signed [COEF_W-1:0]  k1_i,
  input  logic signed [CW-1:0]      v1_i,
  input  logic signed [COEF_W-1:0]  k2_i,
  input  logic signed [CW-1:0]      v2_i,
  input  logic signed [COEF_W-1:0]  t_i,
  output logic signed [FIELD_W-1:0] coord_o,
  output logic                      sat_o
);

  logic signed [PROD_W-1:0]  p1_q, p2_q;
  logic signed [PROD_W-1:0]  pr1_d, pr2_d;
  logic signed [RND_W-1:0]   r1_q, r2_q;
  logic signed [SUM_W-1:0]   s_d, s_q;
  logic signed [CW-1:0]      c_d;
  logic                      sat_d;
  logic signed [FIELD_W-1:0] coord_q;
  logic                      sat_q;

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      p1_q <= PROD_W'(k1_i) * PROD_W'(v1_i);
      p2_q <= PROD_W'(k2_i) * PROD_W'(v2_i);
    end
  end

  // stage 2: round to nearest, ties up
  assign pr1_d = p1_q + ROUND_HALF;
  assign pr2_d = p2_q + ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (en_i.rnd) begin
      r1_q <= pr1_d[PROD_W-1:FRAC_BITS];
      r2_q <= pr2_d[PROD_W-1:FRAC_BITS];
    end
  end

  // stage 3: sum plus translation
  assign s_d = SUM_W'(r1_q) + SUM_W'(r2_q) + SUM_W'(t_i);

  always_ff @(posedge clk_i) begin
    if (en_i.add) begin
      s_q <= s_d;
    end
  end

  // stage 4: clamp
  always_comb begin
    sat_d = 1'b0;
    c_d   = s_q[CW-1:0];
    if (s_q > SAT_HI) begin
      c_d   = COORD_MAX;
      sat_d = 1'b1;
    end else if (s_q < SAT_LO) begin
      c_d   = COORD_MIN;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sat) begin
      coord_q <= FIELD_W'(c_d);
      sat_q   <= sat_d;
    end
  end

  assign coord_o = coord_q;
  assign sat_o   = sat_q;

endmodule

[src/affine_point_transform.sv]
// Affine point transform: x' = a*x + c*y + e, y' = b*x + d*y + f, signed Q16.16.
// Channels: pt_i takes points (x_in, y_in, last_in), res_o delivers results
// (x_out, y_out, last_out, overflow), cfg_i writes the six coefficient registers
// (index 0..5 = a, b, c, d, e, f; higher indexes are dropped). cfg_i is always
// ready; write it only while no point is in flight.
// A point accepted on pt_i passes the multiply, round, add and clamp registers in
// that order before it appears on res_o. Throughput: one point per cycle while res_o
// is not stalled; the first stage holds four parallel 32x32 multipliers.
// Each coordinate is clamped to the signed 32-bit range; overflow is set when
// either one was clamped. last_in travels with its point unchanged.
// Reset empties the pipeline and loads the identity matrix (a = d = 1.0).
// A stall on res_o holds the result; upstream stages keep filling any empty
// stage, so up to four points are buffered before pt_i.ready drops.
`include "assert_macros.svh"

module affine_point_transform import apt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  apt_point_if.sink    pt_i,
  apt_result_if.source res_o,
  apt_cfg_if.sink      cfg_i
);

  coef_t                  coef;
  logic [NUM_STAGES-1:0]  v_q;
  logic [NUM_STAGES-1:0]  last_q;
  logic [NUM_STAGES-1:0]  adv;
  pipe_en_t               en;
  logic signed [CW-1:0]   x_c, y_c;
  logic                   sat_x, sat_y;

  apt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  always_comb begin
    adv[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || res_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign en.mul = adv[0];
  assign en.rnd = adv[1];
  assign en.add = adv[2];
  assign en.sat = adv[3];

  assign pt_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= pt_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      last_q[0] <= pt_i.last_in;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  assign x_c = pt_i.x_in[CW-1:0];
  assign y_c = pt_i.y_in[CW-1:0];

  apt_lane u_lane_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .k1_i    (coef.a),
    .v1_i    (x_c),
    .k2_i    (coef.c),
    .v2_i    (y_c),
    .t_i     (coef.e),
    .coord_o (res_o.x_out),
    .sat_o   (sat_x)
  );

  apt_lane u_lane_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .k1_i    (coef.b),
    .v1_i    (x_c),
    .k2_i    (coef.d),
    .v2_i    (y_c),
    .t_i     (coef.f),
    .coord_o (res_o.y_out),
    .sat_o   (sat_y)
  );

  assign res_o.valid    = v_q[NUM_STAGES-1];
  assign res_o.last_out = last_q[NUM_STAGES-1];
  assign res_o.overflow = sat_x || sat_y;

  `ASSERT_NEXT(a_accept_enters, pt_i.valid && pt_i.ready, v_q[0])
  `ASSERT_NEXT(a_stage0_holds, v_q[0] && !adv[1], v_q[0] && $stable(last_q[0]))
  `ASSERT_IMPLY(a_ovf_clamped, res_o.valid && res_o.overflow,
                res_o.x_out == OUT_MAX || res_o.x_out == OUT_MIN ||
                res_o.y_out == OUT_MAX || res_o.y_out == OUT_MIN)

endmodule
